@@ rtl/bap_pkg.sv @@
// Shared constants, codes and types for the braked approach profile step.
// No dependencies; imported by every module of the block.
package bap_pkg;

  localparam int POS_W     = 15;            // position, unsigned Q7.8
  localparam int VEL_W     = 16;            // velocity, signed Q8.8
  localparam int REG_W     = 15;            // config registers
  localparam int IDX_W     = 2;             // config register index
  localparam int OPD_W     = 15;            // multiplier operand width
  localparam int PROD_W    = 2 * OPD_W;     // product width
  localparam int DIGIT_W   = 2;             // bits consumed per step
  localparam int MUL_STEPS = (OPD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W     = MUL_STEPS * DIGIT_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  localparam logic [IDX_W-1:0] REG_ACCEL     = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEPTH     = 2'd2;

  localparam logic [REG_W-1:0] ACCEL_RST     = 15'd64;
  localparam logic [REG_W-1:0] MAX_SPEED_RST = 15'd1024;
  localparam logic [REG_W-1:0] DEPTH_RST     = 15'd4096;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VEL_W-1:0] vel;
  } upd_res_t;

endpackage

@@ rtl/braked_approach_profile_step.sv @@
// Top level of the braked approach profile step: handshakes, state, sequencer.
// Depends on bap_pkg, bap_ser_mul and bap_update.
//
// Usage: each input item (in_loaded) is one control tick. Target is depth
// while loaded, else 0. The block returns one item per tick with the new
// position (unsigned Q7.8) and velocity (signed Q8.8).
// Channels: in_* and out_* are valid/ready; an item moves when both are high.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 accel,
// 1 max_speed, 2 depth) at the clock edge; write only while idle.
// Timing: the square v*v and the product accel*|dist| run in two 2-bit
// digit-serial multipliers, 8 digit steps each, in parallel. An item goes
// from acceptance through the digit steps, the done check and the update
// to out_valid, and the next item can be accepted in the cycle after the
// result is registered, so items are processed one at a time.
// Reset (rst_n low, synchronous): position and velocity return to 0, config
// to accel 64, max_speed 1024, depth 4096, no result pending.
// Stall: a finished result waits in the output register; a following result
// waits in the update stage until out_ready frees the register.
module braked_approach_profile_step
  import bap_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_loaded,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_W-1:0]        out_position,
  output logic signed [VEL_W-1:0] out_velocity,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [REG_W-1:0]        accel_r, max_speed_r, depth_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VEL_W-1:0] vel_r;
  logic                    dist_pos_r, dist_neg_r, toward_r;
  logic                    out_valid_r;
  logic [POS_W-1:0]        out_pos_r;
  logic signed [VEL_W-1:0] out_vel_r;

  logic                    accept, commit, start;
  logic [POS_W-1:0]        target;
  logic signed [VEL_W-1:0] gap;
  logic [OPD_W-1:0]        adist, aspd;
  logic                    d_pos, d_neg, toward;
  logic [PROD_W-1:0]       vsq, acc_dist;
  mul_stat_t               sq_stat, ad_stat;
  upd_res_t                upd;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // per-tick geometry, taken at acceptance
  always_comb begin
    target = in_loaded ? depth_r : '0;
    gap    = signed'({1'b0, target}) - signed'({1'b0, pos_r});
    d_pos  = (gap > 16'sd0);
    d_neg  = (gap < 16'sd0);
    adist  = d_neg ? OPD_W'(-gap) : OPD_W'(gap);
    aspd   = vel_r[VEL_W-1] ? OPD_W'(-vel_r) : OPD_W'(vel_r);
    toward = (d_pos && (vel_r > 16'sd0)) || (d_neg && (vel_r < 16'sd0));
  end

  bap_ser_mul u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a     (aspd),
    .b     (aspd),
    .prod  (vsq),
    .stat  (sq_stat)
  );

  bap_ser_mul u_ad (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a     (accel_r),
    .b     (adist),
    .prod  (acc_dist),
    .stat  (ad_stat)
  );

  bap_update u_upd (
    .pos       (pos_r),
    .vel       (vel_r),
    .dist_pos  (dist_pos_r),
    .dist_neg  (dist_neg_r),
    .toward    (toward_r),
    .vsq       (vsq),
    .acc_dist  (acc_dist),
    .accel     (accel_r),
    .max_speed (max_speed_r),
    .depth     (depth_r),
    .res       (upd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   if (sq_stat.done && ad_stat.done) state_nxt = S_FIN;
      S_FIN:   if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dist_pos_r <= d_pos;
      dist_neg_r <= d_neg;
      toward_r   <= toward;
    end
    if (commit) begin
      out_pos_r <= upd.pos;
      out_vel_r <= upd.vel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      accel_r     <= ACCEL_RST;
      max_speed_r <= MAX_SPEED_RST;
      depth_r     <= DEPTH_RST;
      pos_r       <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACCEL:     accel_r     <= cfg_wdata;
          REG_MAX_SPEED: max_speed_r <= cfg_wdata;
          REG_DEPTH:     depth_r     <= cfg_wdata;
          default:       ;
        endcase
      end
      if (commit) begin
        pos_r <= upd.pos;
        vel_r <= upd.vel;
      end
      if (commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;

  // both multipliers must run in lockstep
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_stat.busy == ad_stat.busy) && (sq_stat.done == ad_stat.done))
    else $error("multipliers out of step");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (sq_stat.busy && state_r == S_MUL))
    else $error("accepted item did not start the multipliers");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared without an update");

  a_vel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> ((vel_r <= signed'({1'b0, max_speed_r}))
             && (vel_r >= -signed'({1'b0, max_speed_r}))
             && (pos_r <= depth_r)))
    else $error("state left its bounds after update");

endmodule

@@ rtl/bap_ser_mul.sv @@
// Digit-serial unsigned multiplier, two multiplier bits per cycle, MSB first.
// Depends on bap_pkg.
module bap_ser_mul
  import bap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OPD_W-1:0]  a,
  input  logic [OPD_W-1:0]  b,
  output logic [PROD_W-1:0] prod,
  output mul_stat_t         stat
);

  logic [OPD_W-1:0]   a_r, a_nxt;
  logic [PAD_W-1:0]   b_r, b_nxt;
  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DIGIT_W-1:0] dig;
  logic [OPD_W+1:0]   pp;

  assign dig = b_r[PAD_W-1 -: DIGIT_W];
  assign pp  = ({2'b00, a_r} & {(OPD_W+2){dig[0]}})
             + ({1'b0, a_r, 1'b0} & {(OPD_W+2){dig[1]}});

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = PAD_W'(b);
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      b_nxt   = {b_r[PAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      acc_nxt = {acc_r[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(pp);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/bap_update.sv @@
// Braking decision, velocity step and clamp, position integrate and saturate.
// Depends on bap_pkg.
module bap_update
  import bap_pkg::*;
(
  input  logic [POS_W-1:0]        pos,
  input  logic signed [VEL_W-1:0] vel,
  input  logic                    dist_pos,
  input  logic                    dist_neg,
  input  logic                    toward,
  input  logic [PROD_W-1:0]       vsq,
  input  logic [PROD_W-1:0]       acc_dist,
  input  logic [REG_W-1:0]        accel,
  input  logic [REG_W-1:0]        max_speed,
  input  logic [REG_W-1:0]        depth,
  output upd_res_t                res
);

  logic               brake;
  logic signed [16:0] v0, v1, a17, lim17, vcl;
  logic signed [17:0] p1, dep18;

  // stopping distance reached: v*v >= 2*accel*|dist|
  assign brake = toward && ({1'b0, vsq} >= {acc_dist, 1'b0});

  always_comb begin
    v0    = {vel[VEL_W-1], vel};
    a17   = signed'({2'b00, accel});
    lim17 = signed'({2'b00, max_speed});
    v1    = v0;
    if (brake) begin
      if (v0 > 17'sd0) v1 = v0 - a17;
      else if (v0 < 17'sd0) v1 = v0 + a17;
    end else begin
      if (dist_pos) v1 = v0 + a17;
      else if (dist_neg) v1 = v0 - a17;
    end

    vcl = v1;
    if (v1 > lim17) vcl = lim17;
    if (v1 < -lim17) vcl = -lim17;

    dep18 = signed'({3'b000, depth});
    p1    = signed'({3'b000, pos}) + {vcl[16], vcl};
    if (p1 > dep18) p1 = dep18;
    if (p1 < 18'sd0) p1 = 18'sd0;

    res.pos = p1[POS_W-1:0];
    res.vel = vcl[VEL_W-1:0];
  end

endmodule
